@@ design/tcswa_pkg.sv @@
package tcswa_pkg;

	localparam int unsigned HEIGHT_W   = 16;
	localparam int unsigned COORD_W    = 8;
	localparam int unsigned STEEP_W    = 16;
	localparam int unsigned SPACING_W  = 16;
	localparam int unsigned SLOPE_W    = 16;
	// steep * 100 stays below 2^23
	localparam int unsigned DIVIDEND_W = 23;
	localparam int unsigned DIV_CNT_W  = 5;

	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 16'sh7fff;
	localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 16'sh8000;
	localparam logic [SLOPE_W-1:0]         SLOPE_SAT  = 16'hffff;
	localparam logic [SPACING_W-1:0]       SPACING_RESET = 16'd1;

	// one finished cell handed from the front to the back
	typedef struct packed {
		logic [COORD_W-1:0]         cell_x;
		logic [COORD_W-1:0]         cell_y;
		logic [STEEP_W-1:0]         steep;
		logic                       water;
		logic signed [HEIGHT_W-1:0] high;
	} job_t;

endpackage

@@ design/tcswa_front.sv @@
module tcswa_front #(
	parameter int unsigned CELL_EDGE = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [15:0]            height,
	input  logic [7:0]                    cell_x,
	input  logic [7:0]                    cell_y,
	output logic                          job_valid,
	input  logic                          job_full,
	output tcswa_pkg::job_t               job
);
	import tcswa_pkg::*;

	localparam int unsigned SIDE  = CELL_EDGE + 1;
	localparam int unsigned CNT_W = $clog2(SIDE);

	logic [CNT_W-1:0]         col_q;
	logic [CNT_W-1:0]         row_q;
	logic signed [HEIGHT_W-1:0] taps_q [SIDE];
	logic signed [HEIGHT_W-1:0] low_q;
	logic signed [HEIGHT_W-1:0] high_q;
	logic [STEEP_W-1:0]       steep_q;

	logic                     last;
	logic                     accept;
	logic signed [HEIGHT_W:0] diff_row;
	logic signed [HEIGHT_W:0] diff_col;
	logic [HEIGHT_W:0]        mag_row;
	logic [HEIGHT_W:0]        mag_col;
	logic [STEEP_W-1:0]       steep_a;
	logic [STEEP_W-1:0]       steep_next;
	logic signed [HEIGHT_W-1:0] low_next;
	logic signed [HEIGHT_W-1:0] high_next;

	// the last sample of a cell waits only when the queue has no room
	assign last   = (col_q == CNT_W'(SIDE - 1)) && (row_q == CNT_W'(SIDE - 1));
	assign full   = last && job_full;
	assign accept = push && !full;

	// absolute steps to the left neighbor and to the sample one row up
	always_comb begin
		diff_row = {height[HEIGHT_W-1], height} - {taps_q[0][HEIGHT_W-1], taps_q[0]};
		diff_col = {height[HEIGHT_W-1], height} -
			{taps_q[SIDE-1][HEIGHT_W-1], taps_q[SIDE-1]};
		mag_row  = diff_row[HEIGHT_W] ? -diff_row : diff_row;
		mag_col  = diff_col[HEIGHT_W] ? -diff_col : diff_col;
		steep_a  = steep_q;
		if ((col_q != '0) && (mag_row[STEEP_W-1:0] > steep_a)) begin
			steep_a = mag_row[STEEP_W-1:0];
		end
		steep_next = steep_a;
		if ((row_q != '0) && (mag_col[STEEP_W-1:0] > steep_next)) begin
			steep_next = mag_col[STEEP_W-1:0];
		end
		low_next  = (height < low_q)  ? height : low_q;
		high_next = (height > high_q) ? height : high_q;
	end

	// job for the back end, formed from the closing sample
	assign job_valid  = accept && last;
	assign job.cell_x = cell_x;
	assign job.cell_y = cell_y;
	assign job.steep  = steep_next;
	assign job.water  = low_next[HEIGHT_W-1];
	assign job.high   = high_next;

	// running statistics and sample position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			low_q   <= HEIGHT_MAX;
			high_q  <= HEIGHT_MIN;
			steep_q <= '0;
		end else if (accept) begin
			if (last) begin
				col_q   <= '0;
				row_q   <= '0;
				low_q   <= HEIGHT_MAX;
				high_q  <= HEIGHT_MIN;
				steep_q <= '0;
			end else begin
				if (col_q == CNT_W'(SIDE - 1)) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				low_q   <= low_next;
				high_q  <= high_next;
				steep_q <= steep_next;
			end
		end
	end

	// shift line of the last SIDE samples: tap 0 is the left neighbor,
	// the last tap is the sample one row above
	always_ff @(posedge clk) begin
		if (accept) begin
			taps_q[0] <= height;
			for (int i = 1; i < SIDE; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
	end

endmodule

@@ design/tcswa_queue.sv @@
module tcswa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_full,
	input  tcswa_pkg::job_t wr_job,
	output logic            rd_valid,
	input  logic            rd_ready,
	output tcswa_pkg::job_t rd_job
);
	import tcswa_pkg::*;

	localparam int unsigned DEPTH = 2;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_full  = (count_q == (PTR_W+1)'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && !wr_full;
	assign do_rd    = rd_valid && rd_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

@@ design/tcswa_back.sv @@
module tcswa_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          spacing,
	input  logic                 job_valid,
	output logic                 job_ready,
	input  tcswa_pkg::job_t      job,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           out_cell_x,
	output logic [7:0]           out_cell_y,
	output logic [15:0]          slope_percent,
	output logic                 water,
	output logic signed [15:0]   highest_sample
);
	import tcswa_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic [SPACING_W-1:0]    rem_q;
	logic [DIVIDEND_W-1:0]   quo_q;
	job_t                    job_q;
	logic                    res_valid_q;

	logic [DIVIDEND_W-1:0]   dividend;
	logic [SPACING_W:0]      rem_shift;
	logic                    ge;
	logic [SPACING_W:0]      rem_sub;
	logic [SLOPE_W-1:0]      slope;
	logic                    load_res;

	// steep * 100 as shifts and adds
	assign dividend = (DIVIDEND_W'(job.steep) << 6) + (DIVIDEND_W'(job.steep) << 5) +
		(DIVIDEND_W'(job.steep) << 2);

	// one restoring division step per cycle
	always_comb begin
		rem_shift = {rem_q, quo_q[DIVIDEND_W-1]};
		ge        = rem_shift >= {1'b0, spacing};
		rem_sub   = rem_shift - {1'b0, spacing};
		slope     = (quo_q[DIVIDEND_W-1:SLOPE_W] != '0) ? SLOPE_SAT : quo_q[SLOPE_W-1:0];
	end

	assign job_ready = (state_q == ST_IDLE);
	assign empty     = !res_valid_q;
	// result register takes the finished job once it is free or being popped
	assign load_res  = (state_q == ST_DONE) && (!res_valid_q || pop);

	// divider sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			rem_q          <= '0;
			quo_q          <= '0;
			job_q          <= '0;
			res_valid_q    <= 1'b0;
			out_cell_x     <= '0;
			out_cell_y     <= '0;
			slope_percent  <= '0;
			water          <= 1'b0;
			highest_sample <= '0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						quo_q   <= dividend;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= ge ? rem_sub[SPACING_W-1:0] : rem_shift[SPACING_W-1:0];
					quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hand over once the result register is free
					if (load_res) begin
						out_cell_x     <= job_q.cell_x;
						out_cell_y     <= job_q.cell_y;
						slope_percent  <= (spacing == '0) ? SLOPE_SAT : slope;
						water          <= job_q.water;
						highest_sample <= job_q.high;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/terrain_cell_slope_water_analyser.sv @@
// Terrain cell slope and water analyser.
// Input queue side: one signed height sample per transfer (push/full), the
// (CELL_EDGE+1)^2 samples of a cell in row-major order, 25 by default.
// Samples are taken one per cycle when not full; full rises only on the
// closing sample of a cell when the two-entry front-to-back job queue is full.
// Result queue side: one result per cell (empty/pop), holding the cell
// coordinates of the closing sample, slope in percent (saturated), the water
// flag and the highest sample. A result waits on the ports until popped.
// From the closing sample, a cell passes through the job queue and the
// bit-serial divider, and its result is then written to the result
// register. The divider keeps pace with the samples of a cell, so a
// continuous stream is sustained at one per cycle while results are popped.
// A stalled result register holds the divider, then the job queue, then the
// input. Configuration: cfg_valid/cfg_data write sample_spacing (always
// ready); write it only while the block is idle. Reset clears all control
// state and sets sample_spacing to 1; partial cells are discarded.
module terrain_cell_slope_water_analyser #(
	parameter int unsigned CELL_EDGE = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] height,
	input  logic [7:0]         cell_x,
	input  logic [7:0]         cell_y,
	output logic               empty,
	input  logic               pop,
	output logic [7:0]         out_cell_x,
	output logic [7:0]         out_cell_y,
	output logic [15:0]        slope_percent,
	output logic               water,
	output logic signed [15:0] highest_sample,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import tcswa_pkg::*;

	logic [SPACING_W-1:0] spacing_q;
	logic                 fj_valid;
	logic                 fj_full;
	job_t                 fj_job;
	logic                 bj_valid;
	logic                 bj_ready;
	job_t                 bj_job;

	// spacing register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			spacing_q <= cfg_data;
		end
	end

	tcswa_front #(
		.CELL_EDGE (CELL_EDGE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.height    (height),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.job_valid (fj_valid),
		.job_full  (fj_full),
		.job       (fj_job)
	);

	tcswa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fj_valid),
		.wr_full  (fj_full),
		.wr_job   (fj_job),
		.rd_valid (bj_valid),
		.rd_ready (bj_ready),
		.rd_job   (bj_job)
	);

	tcswa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.spacing        (spacing_q),
		.job_valid      (bj_valid),
		.job_ready      (bj_ready),
		.job            (bj_job),
		.empty          (empty),
		.pop            (pop),
		.out_cell_x     (out_cell_x),
		.out_cell_y     (out_cell_y),
		.slope_percent  (slope_percent),
		.water          (water),
		.highest_sample (highest_sample)
	);

endmodule

@@ tb/sv/cell_summary_checker.sv @@
`timescale 1ns / 100ps

// Watches the sample, result and spacing channels of the analyser, keeps its
// own copy of the per-cell state and compares every popped result field by
// field against the oldest predicted cell summary.
module cell_summary_checker
	import tcswa_pkg::*;
#(
	parameter int unsigned CELL_EDGE = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic signed [HEIGHT_W-1:0] height,
	input  logic [COORD_W-1:0]         cell_x,
	input  logic [COORD_W-1:0]         cell_y,
	input  logic                       empty,
	input  logic                       pop,
	input  logic [COORD_W-1:0]         out_cell_x,
	input  logic [COORD_W-1:0]         out_cell_y,
	input  logic [SLOPE_W-1:0]         slope_percent,
	input  logic                       water,
	input  logic signed [HEIGHT_W-1:0] highest_sample,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [SPACING_W-1:0]       cfg_data,
	output int unsigned                pending,
	output int unsigned                fail_count,
	output int unsigned                cells_checked,
	output int unsigned                water_cells,
	output int unsigned                saturated_cells
);

	localparam int unsigned SIDE = CELL_EDGE + 1;
	localparam int unsigned CELL_SAMPLES = SIDE * SIDE;

	typedef struct packed {
		logic [COORD_W-1:0]         cell_x;
		logic [COORD_W-1:0]         cell_y;
		logic [SLOPE_W-1:0]         slope;
		logic                       water;
		logic signed [HEIGHT_W-1:0] high;
	} cell_summary_t;

	cell_summary_t cells_due[$];

	// shadow of the analyser state
	logic [SPACING_W-1:0]       spacing;
	int unsigned                sample_pos;
	logic signed [HEIGHT_W-1:0] upper_row [SIDE];
	logic signed [HEIGHT_W-1:0] left_sample;
	logic signed [HEIGHT_W-1:0] low_mark;
	logic signed [HEIGHT_W-1:0] high_mark;
	logic [STEEP_W-1:0]         steepest;

	int unsigned mismatches = 0;
	int unsigned checked = 0;
	int unsigned wet = 0;
	int unsigned saturated = 0;

	initial begin
		pending = 0;
		fail_count = 0;
		cells_checked = 0;
		water_cells = 0;
		saturated_cells = 0;
	end

	task automatic report_mismatch(input string what, input logic signed [31:0] got,
		input logic signed [31:0] want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// larger of the running steepest step and |a - b|
	function automatic logic [STEEP_W-1:0] steeper(input logic [STEEP_W-1:0] cur,
		input logic signed [HEIGHT_W-1:0] a, input logic signed [HEIGHT_W-1:0] b);
		int diff;
		diff = int'(a) - int'(b);
		if (diff < 0)
			diff = -diff;
		return (diff > int'(cur)) ? diff[STEEP_W-1:0] : cur;
	endfunction

	// fold one sample into the cell; queue a summary on the closing sample
	task automatic absorb_sample(input logic signed [HEIGHT_W-1:0] h,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		int unsigned col;
		int unsigned row;
		int unsigned quotient;
		cell_summary_t due;
		col = sample_pos % SIDE;
		row = sample_pos / SIDE;
		if (col > 0)
			steepest = steeper(steepest, h, left_sample);
		if (row > 0)
			steepest = steeper(steepest, h, upper_row[col]);
		upper_row[col] = h;
		left_sample = h;
		if (h < low_mark)
			low_mark = h;
		if (h > high_mark)
			high_mark = h;
		if (sample_pos + 1 < CELL_SAMPLES) begin
			sample_pos++;
			return;
		end
		if (spacing == 0) begin
			quotient = 32'(SLOPE_SAT);
		end else begin
			quotient = (32'(steepest) * 100) / 32'(spacing);
			if (quotient > 32'(SLOPE_SAT))
				quotient = 32'(SLOPE_SAT);
		end
		due.cell_x = x;
		due.cell_y = y;
		due.slope = quotient[SLOPE_W-1:0];
		due.water = (low_mark < 0);
		due.high = high_mark;
		cells_due = {cells_due, due};
		sample_pos = 0;
		low_mark = HEIGHT_MAX;
		high_mark = HEIGHT_MIN;
		steepest = '0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		cell_summary_t want;
		if (!arst_n) begin
			spacing = SPACING_RESET;
			sample_pos = 0;
			for (int i = 0; i < SIDE; i++)
				upper_row[i] = '0;
			left_sample = '0;
			low_mark = HEIGHT_MAX;
			high_mark = HEIGHT_MIN;
			steepest = '0;
			cells_due.delete();
			pending <= 0;
		end else begin
			// result transfer: compare with the oldest summary
			if (pop && !empty) begin
				if (cells_due.size() == 0) begin
					report_mismatch("result with no cell pending", 32'(slope_percent), 0);
				end else begin
					want = cells_due.pop_front();
					if (out_cell_x !== want.cell_x)
						report_mismatch("out_cell_x", 32'(out_cell_x), 32'(want.cell_x));
					if (out_cell_y !== want.cell_y)
						report_mismatch("out_cell_y", 32'(out_cell_y), 32'(want.cell_y));
					if (slope_percent !== want.slope)
						report_mismatch("slope_percent", 32'(slope_percent),
							32'(want.slope));
					if (water !== want.water)
						report_mismatch("water", 32'(water), 32'(want.water));
					if (highest_sample !== want.high)
						report_mismatch("highest_sample", 32'(highest_sample),
							32'(want.high));
					checked++;
					if (want.water)
						wet++;
					if (want.slope == SLOPE_SAT)
						saturated++;
				end
			end
			if (cfg_valid && cfg_ready)
				spacing = cfg_data;
			if (push && !full)
				absorb_sample(height, cell_x, cell_y);
			pending <= cells_due.size();
		end
		fail_count <= mismatches;
		cells_checked <= checked;
		water_cells <= wet;
		saturated_cells <= saturated;
	end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import tcswa_pkg::*;

	localparam int unsigned CELL_EDGE = 4;
	localparam int unsigned SIDE = CELL_EDGE + 1;
	localparam int unsigned CELL_SAMPLES = SIDE * SIDE;
	localparam int unsigned PHASES = 8;
	localparam int unsigned CELLS_PER_PHASE = 8;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned IDLE_PCT = 11;

	typedef enum {
		TERRAIN_WILD,
		TERRAIN_GENTLE,
		TERRAIN_DRY,
		TERRAIN_SUBMERGED,
		TERRAIN_TERRACED,
		TERRAIN_RIDGED,
		TERRAIN_SPIKE
	} terrain_e;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic                       full;
	logic signed [HEIGHT_W-1:0] height = '0;
	logic [COORD_W-1:0]         cell_x = '0;
	logic [COORD_W-1:0]         cell_y = '0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic [COORD_W-1:0]         out_cell_x;
	logic [COORD_W-1:0]         out_cell_y;
	logic [SLOPE_W-1:0]         slope_percent;
	logic                       water;
	logic signed [HEIGHT_W-1:0] highest_sample;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [SPACING_W-1:0]       cfg_data = '0;

	int unsigned pending;
	int unsigned fail_count;
	int unsigned cells_checked;
	int unsigned water_cells;
	int unsigned saturated_cells;

	int unsigned cycle_count = 0;
	int unsigned samples_sent = 0;
	int unsigned spacing_writes = 0;
	logic        calm = 1'b0;

	terrain_cell_slope_water_analyser u_top (.*);

	cell_summary_checker #(.CELL_EDGE(CELL_EDGE)) u_checker (.*);

	always #2 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// result side: random stalls unless in the calm stretch
	always @(posedge clk)
		pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d cells still pending", cycle_count, pending);
		$display("[terrain_cell_slope_water_analyser] ERROR");
		$finish;
	end

	// one sample transfer, with random gaps ahead of it
	task automatic push_sample(input logic signed [HEIGHT_W-1:0] h,
		input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		height <= h;
		cell_x <= x;
		cell_y <= y;
		@(posedge clk);
		while (full)
			@(posedge clk);
		samples_sent++;
	endtask

	// full cell of a given terrain shape; coordinates only on the closing sample
	task automatic push_cell(input terrain_e shape, input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		int base;
		int level;
		int spike_at;
		int lane_level [SIDE];
		base = int'($urandom_range(0, 65535)) - 32768;
		spike_at = $urandom_range(0, CELL_SAMPLES - 1);
		for (int i = 0; i < SIDE; i++)
			lane_level[i] = int'($urandom_range(0, 65535)) - 32768;
		for (int i = 0; i < CELL_SAMPLES; i++) begin
			case (shape)
				TERRAIN_WILD: level = int'($urandom_range(0, 65535)) - 32768;
				TERRAIN_GENTLE: level = base + int'($urandom_range(0, 600)) - 300;
				TERRAIN_DRY: level = (base & 16'h7fff) / 2 + int'($urandom_range(0, 2000));
				TERRAIN_SUBMERGED: level = -1 - int'($urandom_range(0, 32767));
				TERRAIN_TERRACED: level = lane_level[i / SIDE];
				TERRAIN_RIDGED: level = lane_level[i % SIDE];
				default: level = (i == spike_at) ? lane_level[0] : base;
			endcase
			if (level > 32767)
				level = 32767;
			if (level < -32768)
				level = -32768;
			if (i == CELL_SAMPLES - 1)
				push_sample(level[HEIGHT_W-1:0], x, y);
			else
				push_sample(level[HEIGHT_W-1:0], COORD_W'($urandom), COORD_W'($urandom));
		end
	endtask

	// stop sending and wait out every pending cell
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [SPACING_W-1:0]       spacing;
		logic signed [HEIGHT_W-1:0] h;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < PHASES; p++) begin
			// spacing changes only with nothing in flight
			if (p > 0) begin
				drain();
				case (p)
					1: spacing = '0;
					2: spacing = '1;
					3: spacing = 16'd100;
					4: spacing = 16'd1;
					5: spacing = SPACING_W'($urandom_range(2, 50));
					6: spacing = SPACING_W'($urandom_range(1, 65535));
					default: spacing = 16'd7;
				endcase
				cfg_valid <= 1'b1;
				cfg_data <= spacing;
				@(posedge clk);
				while (!cfg_ready)
					@(posedge clk);
				cfg_valid <= 1'b0;
				spacing_writes++;
			end
			calm = (p == 4);

			// directed cell: full-scale checkerboard with a few small values,
			// coordinate extremes on the first and closing samples
			if (p == 0) begin
				for (int i = 0; i < CELL_SAMPLES; i++) begin
					h = (i % 2) ? HEIGHT_MIN : HEIGHT_MAX;
					if (i == 2)
						h = 16'sd0;
					else if (i == 12)
						h = -16'sd1;
					else if (i == CELL_SAMPLES - 1)
						h = 16'sd1;
					if (i == 0)
						push_sample(h, 8'd0, 8'd255);
					else if (i == CELL_SAMPLES - 1)
						push_sample(h, 8'd255, 8'd0);
					else
						push_sample(h, COORD_W'(i * 10), COORD_W'(255 - i * 10));
				end
			end

			for (int c = 0; c < CELLS_PER_PHASE; c++)
				push_cell(terrain_e'($urandom_range(0, 6)), COORD_W'($urandom),
					COORD_W'($urandom));
		end

		drain();
		$display("covered %0d samples in %0d cells across %0d spacing writes (zero and full scale)",
			samples_sent, cells_checked, spacing_writes);
		$display("%0d cells flagged water, %0d slopes saturated, %0d mismatches",
			water_cells, saturated_cells, fail_count);
		if (fail_count == 0)
			$display("[terrain_cell_slope_water_analyser] OK");
		else
			$display("[terrain_cell_slope_water_analyser] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
design/tcswa_pkg.sv
design/tcswa_front.sv
design/tcswa_queue.sv
design/tcswa_back.sv
design/terrain_cell_slope_water_analyser.sv
tb/sv/cell_summary_checker.sv
tb/sv/tb.sv
